/* sv/spinor_pkg.sv */
`default_nettype none

package spinor_pkg;

    // fixed geometry
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_BITS  = 12;
    localparam int PAGE_BITS    = 8;

    // input item kinds
    localparam logic [1:0] FN_SPI   = 2'd0;
    localparam logic [1:0] FN_EVENT = 2'd1;
    localparam logic [1:0] FN_STORE = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_BAD_ADDR  = 2'd1;
    localparam logic [1:0] ERR_NOT_WEN   = 2'd2;
    localparam logic [1:0] ERR_NOT_BLANK = 2'd3;

    // opcodes
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_FREAD = 8'h0B;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] OP_QPP   = 8'h32;
    localparam logic [7:0] OP_RDSRH = 8'h35;
    localparam logic [7:0] OP_JEDEC = 8'h9F;
    localparam logic [7:0] OP_QREAD = 8'hEB;
    localparam logic [7:0] JEDEC_MFR = 8'hAA;

    // command state codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WAIT  = 4'd1;
    localparam logic [3:0] ST_RDSR  = 4'd2;
    localparam logic [3:0] ST_RDSRH = 4'd3;
    localparam logic [3:0] ST_WRSRA = 4'd4;
    localparam logic [3:0] ST_WRSRB = 4'd5;
    localparam logic [3:0] ST_JID1  = 4'd6;
    localparam logic [3:0] ST_JID2  = 4'd7;
    localparam logic [3:0] ST_JID3  = 4'd8;
    localparam logic [3:0] ST_ADDR2 = 4'd9;
    localparam logic [3:0] ST_ADDR1 = 4'd10;
    localparam logic [3:0] ST_ADDR0 = 4'd11;
    localparam logic [3:0] ST_DUMMY = 4'd12;
    localparam logic [3:0] ST_READ  = 4'd13;
    localparam logic [3:0] ST_WRITE = 4'd14;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_BUSY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUSY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_DELAY = 3'd4;

    typedef struct packed {
        logic [3:0]  fsm;
        logic [7:0]  cmd;
        logic        wen;
        logic        qe;
        logic [23:0] addr;
        logic [1:0]  dummy;
        logic        borrow;
        logic [63:0] deadline;
    } t_spi_state;

    typedef struct packed {
        logic [7:0]  base_block;
        logic [23:0] erase_busy;
        logic [23:0] prog_start_busy;
        logic [23:0] prog_byte_busy;
        logic [23:0] status_write_delay;
    } t_cfg;

    typedef struct packed {
        t_spi_state  nxt;
        logic [7:0]  dout;
        logic [1:0]  err;
        logic        we;
        logic [23:0] wa;
        logic [7:0]  wd;
        logic        erase;
    } t_ctl_out;

    localparam t_spi_state SPI_RESET = '{
        fsm: ST_IDLE, cmd: 8'h00, wen: 1'b0, qe: 1'b1, addr: 24'h0,
        dummy: 2'd0, borrow: 1'b0, deadline: 64'h0
    };

    localparam t_cfg CFG_RESET = '{
        base_block: 8'd0, erase_busy: 24'd100000, prog_start_busy: 24'd100,
        prog_byte_busy: 24'd10, status_write_delay: 24'd1000
    };

endpackage

`default_nettype wire

/* sv/spinor_ctl.sv */
`default_nettype none

module spinor_ctl
    import spinor_pkg::*;
#(
    parameter int FLASH_BYTES = 1048576
) (
    input  wire t_spi_state  i_st,
    input  wire t_cfg        i_cfg,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_data,
    input  wire logic [23:0] i_saddr,
    input  wire logic [63:0] i_now,
    input  wire logic [7:0]  i_rd_data,
    output t_ctl_out         o_ctl
);

    localparam logic [24:0] FLASH_LIM = 25'(FLASH_BYTES);
    localparam logic [7:0]  JID_HI    = 8'((FLASH_BYTES >> 24) & 255);
    localparam logic [7:0]  JID_LO    = 8'((FLASH_BYTES >> 16) & 255);

    always_comb begin
        logic [23:0] addr_v;
        logic [24:0] a_next;
        logic [23:0] a_cur;
        logic [23:0] sec_base;

        addr_v   = i_st.addr | {16'h0, i_data};
        sec_base = {addr_v[23:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
        a_cur    = ({1'b0, i_st.addr} >= FLASH_LIM) ? 24'h0 : i_st.addr;
        a_next   = {1'b0, a_cur} + 25'd1;

        o_ctl       = '0;
        o_ctl.nxt   = i_st;
        o_ctl.dout  = 8'hFF;
        o_ctl.err   = ERR_OK;
        o_ctl.wa    = i_st.addr;
        o_ctl.wd    = i_data;

        unique case (i_func)
            FN_SPI: begin
                unique case (i_st.fsm)
                    ST_IDLE: begin
                        o_ctl.nxt.cmd = i_data;
                        unique case (i_data)
                            OP_WRSR: begin
                                if (i_st.wen) o_ctl.nxt.fsm = ST_WRSRA;
                            end
                            OP_WREN: begin
                                o_ctl.nxt.fsm = ST_WAIT;
                                o_ctl.nxt.wen = 1'b1;
                            end
                            OP_WRDI: begin
                                o_ctl.nxt.fsm = ST_WAIT;
                                o_ctl.nxt.wen = 1'b0;
                            end
                            OP_RDSRH: o_ctl.nxt.fsm = ST_RDSRH;
                            OP_RDSR:  o_ctl.nxt.fsm = ST_RDSR;
                            OP_QREAD, OP_QPP: begin
                                if (i_st.qe) o_ctl.nxt.fsm = ST_ADDR2;
                            end
                            OP_FREAD, OP_PP, OP_SE: o_ctl.nxt.fsm = ST_ADDR2;
                            OP_JEDEC: o_ctl.nxt.fsm = ST_JID1;
                            default: ;
                        endcase
                    end
                    ST_WAIT: ;
                    ST_RDSR: begin
                        o_ctl.dout = {6'h0, i_st.wen, (i_now < i_st.deadline)};
                    end
                    ST_RDSRH: o_ctl.dout = {6'h0, i_st.qe, 1'b0};
                    ST_JID1: begin
                        o_ctl.dout    = JEDEC_MFR;
                        o_ctl.nxt.fsm = ST_JID2;
                    end
                    ST_JID2: begin
                        o_ctl.dout    = JID_HI;
                        o_ctl.nxt.fsm = ST_JID3;
                    end
                    ST_JID3: begin
                        o_ctl.dout    = JID_LO;
                        o_ctl.nxt.fsm = ST_WAIT;
                    end
                    ST_ADDR2: begin
                        o_ctl.nxt.borrow = (i_data < i_cfg.base_block);
                        o_ctl.nxt.addr   = {i_data - i_cfg.base_block, 16'h0};
                        o_ctl.nxt.fsm    = ST_ADDR1;
                    end
                    ST_ADDR1: begin
                        o_ctl.nxt.addr = i_st.addr | {8'h0, i_data, 8'h0};
                        o_ctl.nxt.fsm  = ST_ADDR0;
                    end
                    ST_ADDR0: begin
                        o_ctl.nxt.addr = addr_v;
                        o_ctl.nxt.fsm  = ST_WAIT;
                        if (i_st.borrow || ({1'b0, addr_v} >= FLASH_LIM)) begin
                            o_ctl.err = ERR_BAD_ADDR;
                        end else begin
                            unique case (i_st.cmd)
                                OP_SE: begin
                                    if (i_st.wen) begin
                                        o_ctl.nxt.wen = 1'b0;
                                        o_ctl.wa      = sec_base;
                                        o_ctl.erase   = ({1'b0, sec_base}
                                            + 25'(SECTOR_BYTES)) <= FLASH_LIM;
                                        o_ctl.nxt.deadline =
                                            i_now + {40'h0, i_cfg.erase_busy};
                                    end
                                end
                                OP_QREAD: begin
                                    o_ctl.nxt.dummy = 2'd2;
                                    o_ctl.nxt.fsm   = ST_DUMMY;
                                end
                                OP_FREAD: begin
                                    o_ctl.nxt.dummy = 2'd0;
                                    o_ctl.nxt.fsm   = ST_DUMMY;
                                end
                                OP_QPP, OP_PP: begin
                                    if ((i_st.cmd == OP_PP || i_st.qe) && i_st.wen) begin
                                        o_ctl.nxt.deadline =
                                            i_now + {40'h0, i_cfg.prog_start_busy};
                                        o_ctl.nxt.fsm = ST_WRITE;
                                    end else begin
                                        o_ctl.nxt.wen = 1'b0;
                                        o_ctl.err     = ERR_NOT_WEN;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    ST_DUMMY: begin
                        if (i_st.dummy != 2'd0) o_ctl.nxt.dummy = i_st.dummy - 2'd1;
                        else                    o_ctl.nxt.fsm   = ST_READ;
                    end
                    ST_READ: begin
                        o_ctl.dout     = i_rd_data;
                        o_ctl.nxt.addr = (a_next >= FLASH_LIM) ? 24'h0 : a_next[23:0];
                    end
                    ST_WRITE: begin
                        if ({1'b0, i_st.addr} >= FLASH_LIM) begin
                            o_ctl.nxt.wen = 1'b0;
                            o_ctl.nxt.fsm = ST_WAIT;
                        end else if (i_rd_data != 8'hFF) begin
                            o_ctl.nxt.wen = 1'b0;
                            o_ctl.nxt.fsm = ST_WAIT;
                            o_ctl.err     = ERR_NOT_BLANK;
                        end else begin
                            o_ctl.we           = 1'b1;
                            o_ctl.nxt.addr     = i_st.addr + 24'd1;
                            o_ctl.nxt.deadline =
                                i_st.deadline + {40'h0, i_cfg.prog_byte_busy};
                            if (o_ctl.nxt.addr[PAGE_BITS-1:0] == '0) begin
                                o_ctl.nxt.wen = 1'b0;
                                o_ctl.nxt.fsm = ST_WAIT;
                            end
                        end
                    end
                    ST_WRSRA: o_ctl.nxt.fsm = ST_WRSRB;
                    ST_WRSRB: begin
                        o_ctl.nxt.qe       = i_data[1];
                        o_ctl.nxt.deadline = i_now + {40'h0, i_cfg.status_write_delay};
                        o_ctl.nxt.fsm      = ST_IDLE;
                    end
                    default: o_ctl.nxt.fsm = ST_IDLE;
                endcase
            end
            FN_EVENT: begin
                if (i_data == 8'h00) o_ctl.nxt.fsm = ST_IDLE;
            end
            FN_STORE: begin
                if ({1'b0, i_saddr} < FLASH_LIM) begin
                    o_ctl.we = 1'b1;
                    o_ctl.wa = i_saddr;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/spi_nor_flash_model_top.sv */
// spi nor flash command model, one spi byte per word
//
// input channel: a word is taken on a clock edge with start high and busy
// low. i_func picks a spi byte exchange, a select/format event (code zero
// deselects) or a backdoor byte store to i_store_address.
// output channel: every accepted word gives exactly one result word,
// o_data_out and o_error, shown for one cycle with o_strobe high. the
// strobe is registered in the execute phase; the receiver cannot stall.
// config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data,
// always ready; writes are expected only while the block is idle.
// a word is read from the flash memory through its registered read, then
// executed with write back; busy stays high while it executes.
// a sector erase keeps busy high while the 4096 bytes of the sector are
// rewritten to 0xff one byte per cycle.
// reset: synchronous, active low. after reset busy stays high while the
// whole memory is cleared to 0xff; config writes still work.
`default_nettype none

module spi_nor_flash_model_top
    import spinor_pkg::*;
#(
    parameter int FLASH_BYTES = 1048576
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [7:0]           i_data_in,
    input  wire logic [23:0]          i_store_address,
    input  wire logic [63:0]          i_now,
    // result channel
    output logic                      o_strobe,
    output logic [7:0]                o_data_out,
    output logic [1:0]                o_error,
    // config channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [23:0]          i_cfg_data
);

    localparam int          AW        = $clog2(FLASH_BYTES);
    localparam logic [24:0] FLASH_LIM = 25'(FLASH_BYTES);

    // sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_EXEC  = 2'd1;
    localparam logic [1:0] PH_CLEAR = 2'd2;

    logic [1:0]    r_phase;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_full;
    t_spi_state    r_st;
    t_cfg          r_cfg;
    logic          r_strobe;

    // latched word, no reset needed
    logic [1:0]    r_func;
    logic [7:0]    r_data;
    logic [23:0]   r_saddr;
    logic [63:0]   r_now;
    logic [7:0]    r_dout;
    logic [1:0]    r_err;

    // flash array, one write and one registered read per cycle
    logic [7:0]    r_mem [FLASH_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    t_ctl_out      ctl;
    logic          accept;
    logic          clr_last;

    assign busy        = (r_phase != PH_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_data_out  = r_dout;
    assign o_error     = r_err;

    // read address mirrors the wrap of the read path; out of range reads
    // never reach the result
    assign rd_addr = ({1'b0, r_st.addr} >= FLASH_LIM) ? '0 : r_st.addr[AW-1:0];

    // sweep ends at the sector end for erase, at the array end after reset
    assign clr_last = r_clr_full ? (r_clr_addr == AW'(FLASH_BYTES - 1))
                                 : (r_clr_addr[SECTOR_BITS-1:0] == '1);

    spinor_ctl #(
        .FLASH_BYTES(FLASH_BYTES)
    ) u_ctl (
        .i_st     (r_st),
        .i_cfg    (r_cfg),
        .i_func   (r_func),
        .i_data   (r_data),
        .i_saddr  (r_saddr),
        .i_now    (r_now),
        .i_rd_data(r_rd_data),
        .o_ctl    (ctl)
    );

    // one writer: the clear sweep or the executing word
    always_comb begin
        mem_we = 1'b0;
        mem_wa = ctl.wa[AW-1:0];
        mem_wd = ctl.wd;
        if (r_phase == PH_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = 8'hFF;
        end else if (r_phase == PH_EXEC) begin
            mem_we = ctl.we;
        end
    end

    // execute writes land before the next accept edge reads, so no
    // forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_data  <= i_data_in;
            r_saddr <= i_store_address;
            r_now   <= i_now;
        end
        if (r_phase == PH_EXEC) begin
            r_dout <= ctl.dout;
            r_err  <= ctl.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_clr_addr <= '0;
            r_clr_full <= 1'b1;
            r_st       <= SPI_RESET;
            r_cfg      <= CFG_RESET;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BASE_BLOCK:   r_cfg.base_block         <= i_cfg_data[7:0];
                    CFG_ERASE_BUSY:   r_cfg.erase_busy         <= i_cfg_data;
                    CFG_FIRST_DELAY:  r_cfg.prog_start_busy    <= i_cfg_data;
                    CFG_BYTE_BUSY:    r_cfg.prog_byte_busy     <= i_cfg_data;
                    CFG_STATUS_DELAY: r_cfg.status_write_delay <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_phase)
                PH_IDLE: begin
                    if (start) r_phase <= PH_EXEC;
                end
                PH_EXEC: begin
                    r_st     <= ctl.nxt;
                    r_strobe <= 1'b1;
                    if (ctl.erase) begin
                        // rewrite the sector after the result goes out
                        r_phase    <= PH_CLEAR;
                        r_clr_addr <= ctl.wa[AW-1:0];
                        r_clr_full <= 1'b0;
                    end else begin
                        r_phase <= PH_IDLE;
                    end
                end
                PH_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (clr_last) r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/spinor_chk.sv */
`default_nettype none

module spinor_chk
    import spinor_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic [7:0]  o_data_out,
    input wire logic [1:0]  o_error
);

    // every accepted word gives its result strobe after the execute phase
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("result missing after accepted word");

    // no result strobe without an accepted word before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without accepted word");

    // an error result never drives data
    a_err_idle_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_error != ERR_OK) |-> (o_data_out == 8'hFF))
        else $error("error result with driven data");

    // reset starts the clear sweep, so no word is taken right after
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

bind spi_nor_flash_model_top spinor_chk u_spinor_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_data_out(o_data_out),
    .o_error   (o_error)
);

`default_nettype wire

/* verif/spinor_checker.sv */
module spinor_checker
    import spinor_pkg::*;
#(
    parameter int FLASH_BYTES = 1048576
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [1:0]           func,
    input  wire logic [7:0]           data_in,
    input  wire logic [23:0]          store_address,
    input  wire logic [63:0]          now,
    input  wire logic                 strobe,
    input  wire logic [7:0]           data_out,
    input  wire logic [1:0]           error,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]          cfg_data,
    output int                        fail_count,
    output int                        replies_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] err;
    } t_miso_word;

    localparam logic [31:0] FLASH_SIZE = FLASH_BYTES;

    t_spi_state dev;
    t_cfg       regs;
    // bytes never written since the last erase read back as 0xff
    logic [7:0] flash_img [int unsigned];
    t_miso_word replies_due [$];
    int         fails;

    function automatic logic [7:0] flash_byte(input logic [23:0] a);
        if (flash_img.exists(a)) return flash_img[a];
        return 8'hFF;
    endfunction

    function automatic t_miso_word spi_exchange(input logic [7:0] cin, input logic [63:0] t_now);
        t_miso_word  r;
        logic [7:0]  hi;
        logic [23:0] sec;
        int unsigned i;
        r = '{data: 8'hFF, err: ERR_OK};
        case (dev.fsm)
            ST_IDLE: begin
                dev.cmd = cin;
                case (cin)
                    OP_WRSR: if (dev.wen) dev.fsm = ST_WRSRA;
                    OP_WREN: begin
                        dev.fsm = ST_WAIT;
                        dev.wen = 1'b1;
                    end
                    OP_WRDI: begin
                        dev.fsm = ST_WAIT;
                        dev.wen = 1'b0;
                    end
                    OP_RDSRH: dev.fsm = ST_RDSRH;
                    OP_RDSR:  dev.fsm = ST_RDSR;
                    OP_QREAD, OP_QPP: if (dev.qe) dev.fsm = ST_ADDR2;
                    OP_FREAD, OP_PP, OP_SE: dev.fsm = ST_ADDR2;
                    OP_JEDEC: dev.fsm = ST_JID1;
                    default: ;
                endcase
            end
            ST_WAIT: ;
            ST_RDSR:  r.data = {6'd0, dev.wen, t_now < dev.deadline};
            ST_RDSRH: r.data = {6'd0, dev.qe, 1'b0};
            ST_JID1: begin
                r.data = JEDEC_MFR;
                dev.fsm = ST_JID2;
            end
            ST_JID2: begin
                r.data = FLASH_SIZE[31:24];
                dev.fsm = ST_JID3;
            end
            ST_JID3: begin
                r.data = FLASH_SIZE[23:16];
                dev.fsm = ST_WAIT;
            end
            ST_ADDR2: begin
                hi = cin - regs.base_block;
                dev.borrow = cin < regs.base_block;
                dev.addr = {hi, 16'h0000};
                dev.fsm = ST_ADDR1;
            end
            ST_ADDR1: begin
                dev.addr[15:8] = cin;
                dev.fsm = ST_ADDR0;
            end
            ST_ADDR0: begin
                dev.addr[7:0] = cin;
                dev.fsm = ST_WAIT;
                if (dev.borrow || {8'h00, dev.addr} >= FLASH_SIZE) begin
                    r.err = ERR_BAD_ADDR;
                end else begin
                    case (dev.cmd)
                        OP_SE: if (dev.wen) begin
                            dev.wen = 1'b0;
                            sec = dev.addr;
                            sec[SECTOR_BITS-1:0] = '0;
                            if ({8'h00, sec} + 32'(SECTOR_BYTES) <= FLASH_SIZE) begin
                                for (i = 0; i < SECTOR_BYTES; i++) flash_img.delete(sec + i);
                            end
                            dev.deadline = t_now + 64'(regs.erase_busy);
                        end
                        OP_QREAD: begin
                            dev.dummy = 2'd2;
                            dev.fsm = ST_DUMMY;
                        end
                        OP_FREAD: begin
                            dev.dummy = 2'd0;
                            dev.fsm = ST_DUMMY;
                        end
                        OP_PP, OP_QPP: begin
                            if ((dev.cmd == OP_PP || dev.qe) && dev.wen) begin
                                dev.deadline = t_now + 64'(regs.prog_start_busy);
                                dev.fsm = ST_WRITE;
                            end else begin
                                dev.wen = 1'b0;
                                r.err = ERR_NOT_WEN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUMMY: begin
                if (dev.dummy != 2'd0) dev.dummy = dev.dummy - 2'd1;
                else dev.fsm = ST_READ;
            end
            ST_READ: begin
                if ({8'h00, dev.addr} >= FLASH_SIZE) dev.addr = '0;
                r.data = flash_byte(dev.addr);
                dev.addr = dev.addr + 24'd1;
                if ({8'h00, dev.addr} >= FLASH_SIZE) dev.addr = '0;
            end
            ST_WRITE: begin
                if ({8'h00, dev.addr} >= FLASH_SIZE) begin
                    dev.wen = 1'b0;
                    dev.fsm = ST_WAIT;
                end else if (flash_byte(dev.addr) != 8'hFF) begin
                    dev.wen = 1'b0;
                    dev.fsm = ST_WAIT;
                    r.err = ERR_NOT_BLANK;
                end else begin
                    flash_img[dev.addr] = cin;
                    dev.addr = dev.addr + 24'd1;
                    dev.deadline = dev.deadline + 64'(regs.prog_byte_busy);
                    // programming stops at the page boundary
                    if (dev.addr[PAGE_BITS-1:0] == '0) begin
                        dev.wen = 1'b0;
                        dev.fsm = ST_WAIT;
                    end
                end
            end
            ST_WRSRA: dev.fsm = ST_WRSRB;
            ST_WRSRB: begin
                dev.qe = cin[1];
                dev.deadline = t_now + 64'(regs.status_write_delay);
                dev.fsm = ST_IDLE;
            end
            default: dev.fsm = ST_IDLE;
        endcase
        return r;
    endfunction

    function automatic t_miso_word flash_step(input logic [1:0] fn, input logic [7:0] din,
                                              input logic [23:0] saddr, input logic [63:0] t_now);
        t_miso_word r;
        r = '{data: 8'hFF, err: ERR_OK};
        case (fn)
            FN_SPI:   r = spi_exchange(din, t_now);
            FN_EVENT: if (din == 8'h00) dev.fsm = ST_IDLE;
            FN_STORE: if ({8'h00, saddr} < FLASH_SIZE) flash_img[saddr] = din;
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk) begin
        t_miso_word want;
        if (!rst_n) begin
            dev = SPI_RESET;
            regs = CFG_RESET;
            flash_img.delete();
            replies_due.delete();
            fails = 0;
        end else begin
            // reply first: it belongs to a word taken at an earlier edge
            if (strobe !== 1'b0) begin
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: reply with none due: data %h error %0d",
                                 $time, data_out, error);
                end else begin
                    want = replies_due.pop_front();
                    if (data_out !== want.data || error !== want.err) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: reply mismatch: data exp %h got %h, error exp %0d got %0d",
                                     $time, want.data, data_out, want.err, error);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_BLOCK:   regs.base_block = cfg_data[7:0];
                    CFG_ERASE_BUSY:   regs.erase_busy = cfg_data;
                    CFG_FIRST_DELAY:  regs.prog_start_busy = cfg_data;
                    CFG_BYTE_BUSY:    regs.prog_byte_busy = cfg_data;
                    CFG_STATUS_DELAY: regs.status_write_delay = cfg_data;
                    default: ;
                endcase
            end
            if (start && busy === 1'b0)
                replies_due.push_back(flash_step(func, data_in, store_address, now));
        end
        fail_count <= fails;
        replies_outstanding <= replies_due.size();
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spinor_pkg::*;

    localparam int FLASH_BYTES = 1048576;
    // slowest run: the clearing pass over 1M bytes, up to 24 sector erases
    // and about 600 words with gaps, taken several times over
    localparam int unsigned LIMIT = 5_000_000;
    localparam int unsigned MAX_ERASES = 24;

    // func code with no defined action
    localparam logic [1:0]  FN_UNUSED  = 2'd3;
    // opcode that the command decoder does not know
    localparam logic [7:0]  OP_UNKNOWN = 8'h00;
    localparam logic [23:0] LAST_ADDR  = 24'(FLASH_BYTES - 1);
    localparam logic [7:0]  TOP_BLOCK  = 8'((FLASH_BYTES - 1) >> 16);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_func = FN_SPI;
    logic [7:0]           i_data_in = 8'h00;
    logic [23:0]          i_store_address = 24'h000000;
    logic [63:0]          i_now = 64'h0;
    logic                 o_strobe;
    logic [7:0]           o_data_out;
    logic [1:0]           o_error;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BASE_BLOCK;
    logic [23:0]          i_cfg_data = 24'h000000;

    int          fail_count;
    int          replies_outstanding;
    int unsigned cycle_count = 0;

    // stimulus state
    logic [63:0] now_ctr = 64'h0;   // time value handed to the block with each word
    t_cfg        cfg_set = CFG_RESET; // settings last loaded, used to aim addresses
    int          items_sent = 0;
    int          erase_count = 0;
    bit          steady = 1'b0;     // no sender gaps while set

    always #5 i_clk = ~i_clk;

    spi_nor_flash_model_top #(
        .FLASH_BYTES(FLASH_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_data_in      (i_data_in),
        .i_store_address(i_store_address),
        .i_now          (i_now),
        .o_strobe       (o_strobe),
        .o_data_out     (o_data_out),
        .o_error        (o_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    spinor_checker #(
        .FLASH_BYTES(FLASH_BYTES)
    ) checker_i (
        .clk                (i_clk),
        .rst_n              (i_rst_n),
        .start              (start),
        .busy               (busy),
        .func               (i_func),
        .data_in            (i_data_in),
        .store_address      (i_store_address),
        .now                (i_now),
        .strobe             (o_strobe),
        .data_out           (o_data_out),
        .error              (o_error),
        .cfg_valid          (i_cfg_valid),
        .cfg_ready          (o_cfg_ready),
        .cfg_index          (i_cfg_index),
        .cfg_data           (i_cfg_data),
        .fail_count         (fail_count),
        .replies_outstanding(replies_outstanding)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one word on the item channel; returns at the edge that takes it
    task automatic send_item(input logic [1:0] fn, input logic [7:0] d, input logic [23:0] sa);
        int r;
        // random sender gaps, start low meanwhile
        if (!steady) begin
            while ($urandom_range(0, 99) < 26) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_func <= fn;
        i_data_in <= d;
        i_store_address <= sa;
        i_now <= now_ctr;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        // time mostly creeps forward so the busy bit flips around deadlines;
        // now and then it jumps anywhere to work every bit of the count
        r = $urandom_range(0, 99);
        if (r < 3) now_ctr = {$urandom, $urandom};
        else if (r < 4) now_ctr = '1;
        else now_ctr = now_ctr + 64'($urandom_range(0, 40));
    endtask

    task automatic spi(input logic [7:0] d);
        send_item(FN_SPI, d, 24'($urandom));
    endtask

    task automatic deselect();
        send_item(FN_EVENT, 8'h00, 24'($urandom));
    endtask

    task automatic send_address(input logic [23:0] a);
        spi(a[23:16]);
        spi(a[15:8]);
        spi(a[7:0]);
    endtask

    // usually a write enable first, sometimes left out to hit the refusals
    task automatic maybe_wren();
        if ($urandom_range(0, 99) < 85) begin
            deselect();
            spi(OP_WREN);
        end
        deselect();
    endtask

    // drop start and hold off until every reply has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_outstanding != 0) @(posedge i_clk);
    endtask

    // one config word; valid stays high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_BASE_BLOCK, {16'h0000, c.base_block});
        write_reg(CFG_ERASE_BUSY, c.erase_busy);
        write_reg(CFG_FIRST_DELAY, c.prog_start_busy);
        write_reg(CFG_BYTE_BUSY, c.prog_byte_busy);
        write_reg(CFG_STATUS_DELAY, c.status_write_delay);
        i_cfg_valid <= 1'b0;
        cfg_set = c;
    endtask

    // address bytes as sent on the wire, base block included; mostly a few
    // pages so programs collide with earlier data, plus the memory end
    function automatic logic [23:0] pick_address();
        logic [7:0] hi, mid, lo;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            hi = cfg_set.base_block;
            mid = 8'($urandom_range(0, 3));
        end else if (r < 70) begin
            hi = cfg_set.base_block + TOP_BLOCK;
            mid = 8'hFF;
        end else if (r < 88) begin
            hi = cfg_set.base_block + 8'($urandom_range(0, TOP_BLOCK));
            mid = 8'($urandom);
        end else begin
            // mostly out of range or below the base block
            hi = 8'($urandom);
            mid = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 50) lo = 8'($urandom);
        else if (r < 75) lo = 8'($urandom_range(8'hF0, 8'hFF));
        else lo = 8'h00;
        return {hi, mid, lo};
    endfunction

    // physical address for a backdoor store
    function automatic logic [23:0] pick_store_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return {8'h00, 8'($urandom_range(0, 3)), 8'($urandom)};
        if (r < 80) return 24'($urandom_range(0, FLASH_BYTES - 1));
        return 24'($urandom);
    endfunction

    // a known opcode other than sector erase, whose count is capped, or a random byte
    function automatic logic [7:0] any_opcode();
        case ($urandom_range(0, 11))
            0:  return OP_WRSR;
            1:  return OP_PP;
            2:  return OP_WRDI;
            3:  return OP_RDSR;
            4:  return OP_WREN;
            5:  return OP_FREAD;
            6:  return OP_QPP;
            7:  return OP_RDSRH;
            8:  return OP_JEDEC;
            9:  return OP_QREAD;
            10: return OP_UNKNOWN;
            default: return 8'($urandom);
        endcase
    endfunction

    // one well-formed command with random content, or some noise
    task automatic run_sequence();
        int  r;
        int  n;
        bit  quad;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            // fast or quad read: address, dummy bytes, then data
            quad = 1'($urandom_range(0, 1));
            deselect();
            spi(quad ? OP_QREAD : OP_FREAD);
            send_address(pick_address());
            n = quad ? 3 : 1;
            if ($urandom_range(0, 99) < 15) n = $urandom_range(0, 4);
            repeat (n) spi(8'($urandom));
            repeat ($urandom_range(1, 12)) spi(8'($urandom));
        end else if (r < 42) begin
            // page program, often starting near a page end
            maybe_wren();
            spi(($urandom_range(0, 3) == 0) ? OP_QPP : OP_PP);
            send_address(pick_address());
            repeat ($urandom_range(1, 24))
                spi(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom));
        end else if (r < 47 && erase_count < MAX_ERASES) begin
            maybe_wren();
            spi(OP_SE);
            send_address(pick_address());
            erase_count++;
        end else if (r < 57) begin
            // status bytes repeat until deselect
            deselect();
            spi($urandom_range(0, 1) ? OP_RDSR : OP_RDSRH);
            repeat ($urandom_range(1, 4)) spi(8'($urandom));
        end else if (r < 64) begin
            // status write, qe mostly left set so quad commands get through
            maybe_wren();
            spi(OP_WRSR);
            spi(8'($urandom));
            spi({6'($urandom), ($urandom_range(0, 99) < 70), 1'($urandom)});
            // with write enable set the machine is back at idle: next byte is an opcode
            if ($urandom_range(0, 1)) spi(any_opcode());
        end else if (r < 69) begin
            deselect();
            spi(OP_JEDEC);
            repeat ($urandom_range(1, 5)) spi(8'($urandom));
        end else if (r < 74) begin
            deselect();
            spi($urandom_range(0, 1) ? OP_WREN : OP_WRDI);
            repeat ($urandom_range(0, 2)) spi(8'($urandom));
        end else if (r < 84) begin
            repeat ($urandom_range(1, 4))
                send_item(FN_STORE, 8'($urandom), pick_store_address());
        end else if (r < 92) begin
            // command cut short
            deselect();
            spi(any_opcode());
            repeat ($urandom_range(0, 3)) spi(8'($urandom));
        end else begin
            // noise on every func code, format events included
            repeat ($urandom_range(1, 3))
                send_item(2'($urandom_range(0, 3)),
                          ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom),
                          24'($urandom));
        end
    endtask

    initial begin
        t_cfg next_cfg;
        int   phase;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under reset settings; the first ones wait out the
        // clearing pass after reset
        now_ctr = '1;
        send_item(FN_UNUSED, 8'hFF, 24'hFFFFFF);
        now_ctr = '0;
        send_item(FN_EVENT, 8'hA5, 24'h000000);      // format code, no effect
        send_item(FN_STORE, 8'h00, 24'hFFFFFF);      // store beyond the array, dropped
        send_item(FN_STORE, 8'h3C, LAST_ADDR);       // last byte of the array
        spi(OP_UNKNOWN);
        // fast read of the last byte, then wrap to address zero
        spi(OP_FREAD);
        send_address(LAST_ADDR);
        spi(8'h00);
        spi(8'hFF);
        spi(8'h00);
        // program refused without write enable
        deselect();
        spi(OP_PP);
        send_address(LAST_ADDR);
        // program onto a byte that is not blank
        deselect();
        spi(OP_WREN);
        deselect();
        spi(OP_PP);
        send_address(LAST_ADDR);
        spi(8'h00);
        // write enable dropped by the failure
        deselect();
        spi(OP_RDSR);
        spi(8'hFF);

        // random phases, each under its own settings; the block is drained
        // and not busy before any config word goes in
        for (phase = 0; phase < 4; phase++) begin
            drain();
            while (busy !== 1'b0) @(posedge i_clk);
            case (phase)
                0: next_cfg = '{base_block: 8'h00, erase_busy: 24'd50,
                                prog_start_busy: 24'd20, prog_byte_busy: 24'd3,
                                status_write_delay: 24'd40};
                1: next_cfg = '{base_block: 8'hFF, erase_busy: 24'hFFFFFF,
                                prog_start_busy: 24'hFFFFFF, prog_byte_busy: 24'hFFFFFF,
                                status_write_delay: 24'hFFFFFF};
                2: next_cfg = '{base_block: 8'($urandom_range(1, 254)), erase_busy: 24'd0,
                                prog_start_busy: 24'd0, prog_byte_busy: 24'd0,
                                status_write_delay: 24'd0};
                default: next_cfg = '{base_block: 8'($urandom),
                                      erase_busy: 24'($urandom_range(0, 300)),
                                      prog_start_busy: 24'($urandom_range(0, 300)),
                                      prog_byte_busy: 24'($urandom_range(0, 30)),
                                      status_write_delay: 24'($urandom_range(0, 300))};
            endcase
            load_settings(next_cfg);
            // one whole phase back to back with no sender gaps
            steady = (phase == 2);
            while (items_sent < 30 + (phase + 1) * 130) run_sequence();
        end

        drain();
        // keep the clock running so a stray reply would still be seen
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && replies_outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
